[design/tpbi_pkg.sv]
// Shared types and constants of the timestamped pose buffer.
package tpbi_pkg;

  localparam int TPBI_DEPTH = 16;

  localparam int W_TIME  = 48;
  localparam int W_POS   = 32;
  localparam int W_ANG   = 16;
  localparam int W_HEAD  = 18;
  localparam int W_ENTRY = W_TIME + 3 * W_POS + 3 * W_ANG;
  localparam int W_OUT   = 200;
  localparam int W_MAG   = 32;
  localparam int W_PROD  = W_MAG + W_TIME;
  localparam int W_QUO   = 41;

  localparam int TURN    = 36000;
  localparam int WRAP_HI = 30000;
  localparam int WRAP_LO = 10000;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEPTH  = 2'd0;
  localparam logic [1:0] CFG_EXT_EN = 2'd1;
  localparam logic [1:0] CFG_EXT_LIM = 2'd2;

  // Command codes.
  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_LATEST = 2'd2;

  typedef enum logic [2:0] {
    ST_STORED = 3'd0,
    ST_DUP    = 3'd1,
    ST_INTERP = 3'd2,
    ST_EXTRAP = 3'd3,
    ST_NEAR   = 3'd4,
    ST_FAR    = 3'd5,
    ST_EMPTY  = 3'd6,
    ST_LATEST = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    L_X     = 3'd0,
    L_Y     = 3'd1,
    L_Z     = 3'd2,
    L_HEAD  = 3'd3,
    L_PITCH = 3'd4,
    L_ROLL  = 3'd5
  } lane_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_SCAN, S_SCANW, S_PSCAN, S_SHR, S_SHW,
    S_RDA, S_RDAW, S_RDBW, S_CHK, S_LANE, S_LWAIT, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    MD_IDLE, MD_MUL, MD_HALF, MD_DIV
  } md_state_t;

  // Operands of one scaled step: round(mag * n / den).
  typedef struct packed {
    logic [W_MAG-1:0]  mag;
    logic [W_TIME-1:0] n;
    logic [W_TIME-1:0] den;
  } md_req_t;

endpackage

[design/tpbi_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tpbi_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/tpbi_muldiv.sv]
// Serial multiply then restoring divide: round(mag * n / den), clamped to 2^40.
module tpbi_muldiv (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  tpbi_pkg::md_req_t                req,
  output logic                             done,
  output logic [tpbi_pkg::W_QUO-1:0]       q_out
);

  localparam int WP = tpbi_pkg::W_PROD;
  localparam int WT = tpbi_pkg::W_TIME;
  localparam int WQ = tpbi_pkg::W_QUO;
  localparam logic [WQ-1:0] QMAX = {1'b1, {(WQ-1){1'b0}}};

  tpbi_pkg::md_state_t st;
  logic [6:0]                 cnt;
  logic [WP-1:0]              acc;
  logic [WT-1:0]              nsh;
  logic [WT-1:0]              den;
  logic [tpbi_pkg::W_MAG-1:0] mag;
  logic [WT-1:0]              rem;
  logic [WQ-1:0]              q;
  logic                       ovf;
  logic [WT:0]                rem2;
  logic                       ge;

  // One division step.
  assign rem2 = {rem, acc[WP-1]};
  assign ge   = rem2 >= {1'b0, den};

  // Clamp of the quotient magnitude.
  assign q_out = (ovf || q > QMAX) ? QMAX : q;

  // Sequencer and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= tpbi_pkg::MD_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        tpbi_pkg::MD_IDLE: begin
          if (start) begin
            mag <= req.mag;
            nsh <= req.n;
            den <= req.den;
            acc <= '0;
            cnt <= 7'(WT - 1);
            st  <= tpbi_pkg::MD_MUL;
          end
        end
        tpbi_pkg::MD_MUL: begin
          acc <= {acc[WP-2:0], 1'b0} + (nsh[WT-1] ? WP'(mag) : '0);
          nsh <= {nsh[WT-2:0], 1'b0};
          cnt <= cnt - 7'd1;
          if (cnt == '0) begin
            st <= tpbi_pkg::MD_HALF;
          end
        end
        tpbi_pkg::MD_HALF: begin
          acc <= acc + WP'(den[WT-1:1]);
          rem <= '0;
          q   <= '0;
          ovf <= 1'b0;
          cnt <= 7'(WP - 1);
          st  <= tpbi_pkg::MD_DIV;
        end
        tpbi_pkg::MD_DIV: begin
          rem <= ge ? WT'(rem2 - {1'b0, den}) : rem2[WT-1:0];
          acc <= {acc[WP-2:0], 1'b0};
          ovf <= ovf | q[WQ-1];
          q   <= {q[WQ-2:0], ge};
          cnt <= cnt - 7'd1;
          if (cnt == '0) begin
            done <= 1'b1;
            st   <= tpbi_pkg::MD_IDLE;
          end
        end
        default: st <= tpbi_pkg::MD_IDLE;
      endcase
    end
  end

endmodule

[design/timestamped_pose_buffer_interp.sv]
// Top level of the timestamped pose buffer with linear interpolation.
// Poses live in a circular RAM kept sorted by time; one request is handled at a
// time and s_tready is low while it is worked on. A push scans the stored
// entries and, unless its time is already stored, moves the later ones up.
// A latest read fetches the newest entry. A query scans like a push, reads two
// entries, then runs six scaled steps through one shared serial
// multiplier-divider; that unit sets the query rate. The result waits in an
// output register, so the next request is taken while it is still unread. No
// clearing pass is needed after reset.
module timestamped_pose_buffer_interp #(
  parameter int DEPTH = tpbi_pkg::TPBI_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,   // time_us, pos_x, pos_y, pos_z, heading, tilt_pitch, tilt_roll
  input  logic [1:0]   s_tuser,   // cmd
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [199:0] m_tdata,   // out_time_us, out_x, out_y, out_z, out_heading, out_pitch,
                                  // out_roll, zero fill
  output logic [2:0]   m_tuser,   // status
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WE = tpbi_pkg::W_ENTRY;
  localparam int WT = tpbi_pkg::W_TIME;

  tpbi_pkg::state_t  state, state_next;
  tpbi_pkg::status_t status;
  tpbi_pkg::lane_t   lane;

  logic [4:0]    depth_q;
  logic          ext_en;
  logic [31:0]   ext_lim;
  logic [AW-1:0] head;
  logic [CW-1:0] count, idx, kk, i1, i2, lim;
  logic          eq_flag, extrap, emit_only;
  logic [1:0]    cmd;
  logic [WE-1:0] in_r, ent_a, ent_b;
  logic [WT-1:0] n_r, den_r;

  logic [WT-1:0]          w_time;
  logic signed [31:0]     w_x, w_y, w_z;
  logic signed [17:0]     w_h;
  logic signed [15:0]     w_p, w_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [WE-1:0] ram_wdata, ram_rdata;

  logic          md_start, md_done;
  logic [tpbi_pkg::W_QUO-1:0] md_q;
  tpbi_pkg::md_req_t md_req;

  // Map a position in time order to a RAM address.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [CW-1:0] li);
    logic [AW+1:0] s;
    s = (AW+2)'(base) + (AW+2)'(li);
    if (s >= (AW+2)'(DEPTH)) s = s - (AW+2)'(DEPTH);
    return s[AW-1:0];
  endfunction

  assign s_tready  = state == tpbi_pkg::S_IDLE;
  assign cfg_ready = 1'b1;

  // Effective depth limit.
  always_comb begin
    if (depth_q == 5'd0) lim = CW'(1);
    else if (32'(depth_q) > 32'(DEPTH)) lim = CW'(DEPTH);
    else lim = CW'(depth_q);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_q <= 5'd16;
      ext_en  <= 1'b0;
      ext_lim <= 32'd100000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tpbi_pkg::CFG_DEPTH:   depth_q <= cfg_data[4:0];
        tpbi_pkg::CFG_EXT_EN:  ext_en  <= cfg_data[0];
        tpbi_pkg::CFG_EXT_LIM: ext_lim <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pose storage.
  tpbi_ram #(.W(WE), .D(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // Shared multiplier-divider.
  tpbi_muldiv u_md (
    .clk(clk), .rst(rst), .start(md_start), .req(md_req), .done(md_done), .q_out(md_q)
  );

  // Operands of the current lane.
  logic signed [17:0] h1, h2, h1a, h2a;
  logic signed [33:0] p1, p2, d, dmag;
  logic               dneg;
  logic signed [43:0] qs, res, hw;
  logic [WT-1:0]      t_in, t1, t2;

  assign t_in = in_r[WT-1:0];
  assign t1   = ent_a[WT-1:0];
  assign t2   = ent_b[WT-1:0];

  always_comb begin
    h1  = {2'b00, ent_a[159:144]};
    h2  = {2'b00, ent_b[159:144]};
    h1a = h1;
    h2a = h2;
    // Unwrap heading across the zero crossing.
    if (h1 > 18'sd30000 && h2 < 18'sd10000) h1a = h1 - 18'(tpbi_pkg::TURN);
    if (h1 < 18'sd10000 && h2 > 18'sd30000) h2a = h2 - 18'(tpbi_pkg::TURN);
    unique case (lane)
      tpbi_pkg::L_X: begin
        p1 = {{2{ent_a[79]}}, ent_a[79:48]};
        p2 = {{2{ent_b[79]}}, ent_b[79:48]};
      end
      tpbi_pkg::L_Y: begin
        p1 = {{2{ent_a[111]}}, ent_a[111:80]};
        p2 = {{2{ent_b[111]}}, ent_b[111:80]};
      end
      tpbi_pkg::L_Z: begin
        p1 = {{2{ent_a[143]}}, ent_a[143:112]};
        p2 = {{2{ent_b[143]}}, ent_b[143:112]};
      end
      tpbi_pkg::L_HEAD: begin
        p1 = {{16{h1a[17]}}, h1a};
        p2 = {{16{h2a[17]}}, h2a};
      end
      tpbi_pkg::L_PITCH: begin
        p1 = {{18{ent_a[175]}}, ent_a[175:160]};
        p2 = {{18{ent_b[175]}}, ent_b[175:160]};
      end
      tpbi_pkg::L_ROLL: begin
        p1 = {{18{ent_a[191]}}, ent_a[191:176]};
        p2 = {{18{ent_b[191]}}, ent_b[191:176]};
      end
      default: begin
        p1 = '0;
        p2 = '0;
      end
    endcase
    d    = extrap ? p1 - p2 : p2 - p1;
    dneg = d[33];
    dmag = dneg ? -d : d;
    md_req.mag = dmag[31:0];
    md_req.n   = n_r;
    md_req.den = den_r;
    qs  = dneg ? -{3'b000, md_q} : {3'b000, md_q};
    res = {{10{p1[33]}}, p1} + qs;
    // Heading wraps once here and is limited to -72000..107999 when stored.
    if (res >= 44'sd36000) hw = res - 44'sd36000;
    else if (res < 44'sd0) hw = res + 44'sd36000;
    else hw = res;
  end

  // Emission source: fresh read data or the stored nearest entry.
  logic [WE-1:0] emit_ent;
  assign emit_ent = (state == tpbi_pkg::S_RDAW) ? ram_rdata : ent_a;

  // Next state, RAM access and unit start.
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = phys(head, idx);
    ram_wdata  = in_r;
    ram_raddr  = phys(head, idx);
    md_start   = 1'b0;
    unique case (state)
      tpbi_pkg::S_IDLE: if (s_tvalid) state_next = tpbi_pkg::S_DISP;
      tpbi_pkg::S_DISP: begin
        priority case (cmd)
          tpbi_pkg::CMD_PUSH: state_next = tpbi_pkg::S_SCAN;
          tpbi_pkg::CMD_QUERY: begin
            if (count == '0) state_next = tpbi_pkg::S_OUT;
            else if (count == CW'(1)) state_next = tpbi_pkg::S_RDA;
            else state_next = tpbi_pkg::S_SCAN;
          end
          tpbi_pkg::CMD_LATEST: begin
            if (count == '0) state_next = tpbi_pkg::S_OUT;
            else state_next = tpbi_pkg::S_RDA;
          end
          default: state_next = tpbi_pkg::S_IDLE;
        endcase
      end
      tpbi_pkg::S_SCAN: begin
        if (idx == count) state_next = tpbi_pkg::S_PSCAN;
        else state_next = tpbi_pkg::S_SCANW;
      end
      tpbi_pkg::S_SCANW: begin
        if (ram_rdata[WT-1:0] < t_in) state_next = tpbi_pkg::S_SCAN;
        else state_next = tpbi_pkg::S_PSCAN;
      end
      tpbi_pkg::S_PSCAN: begin
        if (cmd == tpbi_pkg::CMD_PUSH) begin
          state_next = eq_flag ? tpbi_pkg::S_OUT : tpbi_pkg::S_SHR;
        end else begin
          state_next = tpbi_pkg::S_RDA;
        end
      end
      tpbi_pkg::S_SHR: begin
        if (kk == idx) begin
          ram_we     = 1'b1;
          state_next = tpbi_pkg::S_OUT;
        end else begin
          ram_raddr  = phys(head, kk - CW'(1));
          state_next = tpbi_pkg::S_SHW;
        end
      end
      tpbi_pkg::S_SHW: begin
        ram_we     = 1'b1;
        ram_waddr  = phys(head, kk);
        ram_wdata  = ram_rdata;
        state_next = tpbi_pkg::S_SHR;
      end
      tpbi_pkg::S_RDA: begin
        ram_raddr  = phys(head, i1);
        state_next = tpbi_pkg::S_RDAW;
      end
      tpbi_pkg::S_RDAW: begin
        ram_raddr  = phys(head, i2);
        state_next = emit_only ? tpbi_pkg::S_OUT : tpbi_pkg::S_RDBW;
      end
      tpbi_pkg::S_RDBW: state_next = tpbi_pkg::S_CHK;
      tpbi_pkg::S_CHK: begin
        if (extrap && (!ext_en || (t_in >= t1 ? t_in - t1 : t1 - t_in) > WT'(ext_lim))) begin
          state_next = tpbi_pkg::S_OUT;
        end else begin
          state_next = tpbi_pkg::S_LANE;
        end
      end
      tpbi_pkg::S_LANE: begin
        md_start   = 1'b1;
        state_next = tpbi_pkg::S_LWAIT;
      end
      tpbi_pkg::S_LWAIT: begin
        if (md_done) begin
          state_next = (lane == tpbi_pkg::L_ROLL) ? tpbi_pkg::S_OUT : tpbi_pkg::S_LANE;
        end
      end
      tpbi_pkg::S_OUT: if (!m_tvalid || m_tready) state_next = tpbi_pkg::S_IDLE;
      default: state_next = tpbi_pkg::S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= tpbi_pkg::S_IDLE;
    else state <= state_next;
  end

  // Buffer control and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // A taken result is dropped unless a new one is loaded in the same cycle.
      if (m_tvalid && m_tready && state != tpbi_pkg::S_OUT) m_tvalid <= 1'b0;
      unique case (state)
        tpbi_pkg::S_IDLE: begin
          if (s_tvalid) begin
            cmd    <= s_tuser;
            in_r   <= s_tdata;
            w_time <= s_tdata[WT-1:0];
            w_x    <= '0;
            w_y    <= '0;
            w_z    <= '0;
            w_h    <= '0;
            w_p    <= '0;
            w_r    <= '0;
          end
        end
        tpbi_pkg::S_DISP: begin
          idx       <= '0;
          i1        <= (cmd == tpbi_pkg::CMD_LATEST) ? count - CW'(1) : '0;
          emit_only <= 1'b1;
          priority case (cmd)
            tpbi_pkg::CMD_PUSH: begin
              // Evict the oldest entry when the buffer is full.
              if (count >= lim && count != '0) begin
                head  <= phys(head, CW'(1));
                count <= count - CW'(1);
              end
            end
            tpbi_pkg::CMD_QUERY: begin
              status <= (count == '0) ? tpbi_pkg::ST_EMPTY : tpbi_pkg::ST_NEAR;
            end
            tpbi_pkg::CMD_LATEST: begin
              status <= (count == '0) ? tpbi_pkg::ST_EMPTY : tpbi_pkg::ST_LATEST;
              if (count == '0) w_time <= '0;
            end
            default: ;
          endcase
        end
        tpbi_pkg::S_SCAN: if (idx == count) eq_flag <= 1'b0;
        tpbi_pkg::S_SCANW: begin
          if (ram_rdata[WT-1:0] < t_in) idx <= idx + CW'(1);
          else eq_flag <= ram_rdata[WT-1:0] == t_in;
        end
        tpbi_pkg::S_PSCAN: begin
          kk <= count;
          if (cmd == tpbi_pkg::CMD_PUSH) begin
            status <= tpbi_pkg::ST_DUP;
          end else if (idx == count) begin
            i1 <= count - CW'(1); i2 <= count - CW'(2); extrap <= 1'b1; emit_only <= 1'b0;
          end else if (idx == '0) begin
            i1 <= '0; i2 <= CW'(1); extrap <= 1'b1;
            emit_only <= eq_flag;
            status    <= tpbi_pkg::ST_NEAR;
          end else begin
            i1 <= idx - CW'(1); i2 <= idx; extrap <= 1'b0; emit_only <= 1'b0;
          end
        end
        tpbi_pkg::S_SHR: begin
          if (kk == idx) begin
            count  <= count + CW'(1);
            status <= tpbi_pkg::ST_STORED;
          end
        end
        tpbi_pkg::S_SHW: kk <= kk - CW'(1);
        tpbi_pkg::S_RDAW: ent_a <= ram_rdata;
        tpbi_pkg::S_RDBW: ent_b <= ram_rdata;
        tpbi_pkg::S_CHK: begin
          lane <= tpbi_pkg::L_X;
          if (extrap) begin
            n_r    <= t_in >= t1 ? t_in - t1 : t1 - t_in;
            den_r  <= t2 >= t1 ? t2 - t1 : t1 - t2;
            status <= !ext_en ? tpbi_pkg::ST_NEAR :
                      ((t_in >= t1 ? t_in - t1 : t1 - t_in) > WT'(ext_lim)) ?
                      tpbi_pkg::ST_FAR : tpbi_pkg::ST_EXTRAP;
          end else begin
            n_r    <= t_in - t1;
            den_r  <= t2 - t1;
            status <= tpbi_pkg::ST_INTERP;
          end
        end
        tpbi_pkg::S_LWAIT: begin
          if (md_done) begin
            lane <= tpbi_pkg::lane_t'(lane + 3'd1);
            unique case (lane)
              tpbi_pkg::L_X: w_x <= (res > 44'sd2147483647) ? 32'sh7FFFFFFF :
                                    (res < -44'sd2147483648) ? 32'sh80000000 : res[31:0];
              tpbi_pkg::L_Y: w_y <= (res > 44'sd2147483647) ? 32'sh7FFFFFFF :
                                    (res < -44'sd2147483648) ? 32'sh80000000 : res[31:0];
              tpbi_pkg::L_Z: w_z <= (res > 44'sd2147483647) ? 32'sh7FFFFFFF :
                                    (res < -44'sd2147483648) ? 32'sh80000000 : res[31:0];
              tpbi_pkg::L_HEAD: w_h <= (hw > 44'sd107999) ? 18'sd107999 :
                                       (hw < -44'sd72000) ? -18'sd72000 : hw[17:0];
              tpbi_pkg::L_PITCH: w_p <= (res > 44'sd32767) ? 16'sh7FFF :
                                        (res < -44'sd32768) ? 16'sh8000 : res[15:0];
              tpbi_pkg::L_ROLL: w_r <= (res > 44'sd32767) ? 16'sh7FFF :
                                       (res < -44'sd32768) ? 16'sh8000 : res[15:0];
              default: ;
            endcase
          end
        end
        tpbi_pkg::S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= status;
            m_tdata  <= {6'b0, w_r, w_p, w_h, w_z, w_y, w_x, w_time};
          end
        end
        default: ;
      endcase
      // Return a stored entry unchanged.
      if ((state == tpbi_pkg::S_RDAW && emit_only) ||
          (state == tpbi_pkg::S_CHK && state_next == tpbi_pkg::S_OUT)) begin
        w_x <= emit_ent[79:48];
        w_y <= emit_ent[111:80];
        w_z <= emit_ent[143:112];
        w_h <= {2'b00, emit_ent[159:144]};
        w_p <= emit_ent[175:160];
        w_r <= emit_ent[191:176];
        if (status == tpbi_pkg::ST_LATEST) w_time <= emit_ent[WT-1:0];
      end
    end
  end

endmodule

[design/tpbi_chk.sv]
// Port-level checker for the pose buffer, bound to the top level.
module tpbi_chk (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [199:0] m_tdata,
  input logic [2:0]   m_tuser
);

  // The block comes out of reset ready with no result pending.
  a_reset: assert property (@(posedge clk) rst |=> (!m_tvalid && s_tready))
    else $error("state after reset wrong");

  // After a request is taken, s_tready is low in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while busy");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // Push and empty results carry no pose.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == 3'(tpbi_pkg::ST_STORED) || m_tuser == 3'(tpbi_pkg::ST_DUP) ||
                  m_tuser == 3'(tpbi_pkg::ST_EMPTY))) |-> (m_tdata[199:48] == '0))
    else $error("pose fields not zero");

endmodule

bind timestamped_pose_buffer_interp tpbi_chk u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

[dv/tb_timestamped_pose_buffer_interp.sv]
// Self-checking testbench of the timestamped pose buffer with linear interpolation.
`timescale 1ns / 1ps

module tb_timestamped_pose_buffer_interp;

  typedef struct {
    logic [1:0]         cmd;
    logic [47:0]        t;
    logic signed [31:0] x, y, z;
    logic [15:0]        hd;
    logic signed [15:0] pt, rl;
  } pose_req_t;

  typedef struct {
    tpbi_pkg::status_t  st;
    logic [47:0]        t;
    logic signed [31:0] x, y, z;
    logic [17:0]        hd;
    logic signed [15:0] pt, rl;
  } pose_res_t;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [47:0] T_MAX = 48'hFFFF_FFFF_FFFF;
  localparam int WATCH_LIMIT = 20000;
  localparam int SETTLE = 1000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [191:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [199:0] m_tdata;
  logic [2:0]   m_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  timestamped_pose_buffer_interp dut (.*);

  always #1 clk = ~clk;

  // Predictor state: the sorted pose store and the register copies.
  logic [47:0]        buf_t [16];
  logic signed [31:0] buf_x [16], buf_y [16], buf_z [16];
  logic [15:0]        buf_h [16];
  logic signed [15:0] buf_p [16], buf_r [16];
  int                 buf_n = 0;
  logic [4:0]         depth_reg = 5'd16;
  logic               extrap_en = 1'b0;
  logic [31:0]        extrap_lim = 32'd100000;

  pose_req_t pending [$];
  pose_res_t expected_poses [$];
  logic      idle_on = 1'b1;
  int        errors = 0;
  int        n_req = 0;
  int        n_res = 0;
  int        n_blend = 0;

  function automatic longint clampv(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Rounded d * n / den, magnitude clamped to 2^40.
  function automatic longint scaled_step(longint d, logic [47:0] n, logic [47:0] den);
    logic [127:0] mag, p, q;
    mag = 128'(d < 0 ? -d : d);
    p = mag * {80'd0, n} + {80'd0, den >> 1};
    q = p / {80'd0, den};
    if (q > (128'd1 << 40)) q = 128'd1 << 40;
    return d < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint blend(longint p1, longint p2, logic ex, logic [47:0] n,
                                   logic [47:0] den);
    return p1 + scaled_step(ex ? p1 - p2 : p2 - p1, n, den);
  endfunction

  function automatic void load_entry(int i, ref pose_res_t r);
    r.x = buf_x[i]; r.y = buf_y[i]; r.z = buf_z[i];
    r.hd = {2'b00, buf_h[i]}; r.pt = buf_p[i]; r.rl = buf_r[i];
  endfunction

  function automatic tpbi_pkg::status_t push_pose(pose_req_t q);
    int lim, p;
    lim = depth_reg == 0 ? 1 : (depth_reg > 16 ? 16 : depth_reg);
    // Evict the oldest one when full, even if the new pose turns out a duplicate.
    if (buf_n >= lim && buf_n > 0) begin
      for (int k = 1; k < buf_n; k++) begin
        buf_t[k-1] = buf_t[k]; buf_x[k-1] = buf_x[k]; buf_y[k-1] = buf_y[k];
        buf_z[k-1] = buf_z[k]; buf_h[k-1] = buf_h[k]; buf_p[k-1] = buf_p[k];
        buf_r[k-1] = buf_r[k];
      end
      buf_n--;
    end
    p = 0;
    while (p < buf_n && buf_t[p] < q.t) p++;
    if (p < buf_n && buf_t[p] == q.t) return tpbi_pkg::ST_DUP;
    for (int k = buf_n; k > p; k--) begin
      buf_t[k] = buf_t[k-1]; buf_x[k] = buf_x[k-1]; buf_y[k] = buf_y[k-1];
      buf_z[k] = buf_z[k-1]; buf_h[k] = buf_h[k-1]; buf_p[k] = buf_p[k-1];
      buf_r[k] = buf_r[k-1];
    end
    buf_t[p] = q.t; buf_x[p] = q.x; buf_y[p] = q.y; buf_z[p] = q.z;
    buf_h[p] = q.hd; buf_p[p] = q.pt; buf_r[p] = q.rl;
    buf_n++;
    return tpbi_pkg::ST_STORED;
  endfunction

  function automatic tpbi_pkg::status_t query_pose(logic [47:0] t, ref pose_res_t r);
    int lb, i1, i2;
    logic ex;
    logic [47:0] n, den;
    longint h1, h2, hv;
    if (buf_n == 0) return tpbi_pkg::ST_EMPTY;
    if (buf_n == 1) begin
      load_entry(0, r);
      return tpbi_pkg::ST_NEAR;
    end
    lb = 0;
    while (lb < buf_n && buf_t[lb] < t) lb++;
    if (lb == buf_n) begin
      i1 = buf_n - 1; i2 = i1 - 1; ex = 1'b1;
    end else if (lb == 0) begin
      if (buf_t[0] == t) begin
        load_entry(0, r);
        return tpbi_pkg::ST_NEAR;
      end
      i1 = 0; i2 = 1; ex = 1'b1;
    end else begin
      i1 = lb - 1; i2 = lb; ex = 1'b0;
    end
    if (ex) begin
      if (!extrap_en) begin
        load_entry(i1, r);
        return tpbi_pkg::ST_NEAR;
      end
      n = t >= buf_t[i1] ? t - buf_t[i1] : buf_t[i1] - t;
      if (n > {16'd0, extrap_lim}) begin
        load_entry(i1, r);
        return tpbi_pkg::ST_FAR;
      end
      den = buf_t[i2] >= buf_t[i1] ? buf_t[i2] - buf_t[i1] : buf_t[i1] - buf_t[i2];
    end else begin
      n = t - buf_t[i1];
      den = buf_t[i2] - buf_t[i1];
    end
    r.x = 32'(clampv(blend(buf_x[i1], buf_x[i2], ex, n, den),
                     -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1));
    r.y = 32'(clampv(blend(buf_y[i1], buf_y[i2], ex, n, den),
                     -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1));
    r.z = 32'(clampv(blend(buf_z[i1], buf_z[i2], ex, n, den),
                     -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1));
    // Unwrap the azimuth across north, blend, then wrap back once.
    h1 = longint'(buf_h[i1]);
    h2 = longint'(buf_h[i2]);
    if (h1 > tpbi_pkg::WRAP_HI && h2 < tpbi_pkg::WRAP_LO) h1 -= tpbi_pkg::TURN;
    if (h1 < tpbi_pkg::WRAP_LO && h2 > tpbi_pkg::WRAP_HI) h2 -= tpbi_pkg::TURN;
    hv = blend(h1, h2, ex, n, den);
    if (hv >= tpbi_pkg::TURN) hv -= tpbi_pkg::TURN;
    else if (hv < 0) hv += tpbi_pkg::TURN;
    r.hd = 18'(clampv(hv, -72000, 107999));
    r.pt = 16'(clampv(blend(buf_p[i1], buf_p[i2], ex, n, den), -32768, 32767));
    r.rl = 16'(clampv(blend(buf_r[i1], buf_r[i2], ex, n, den), -32768, 32767));
    n_blend++;
    return ex ? tpbi_pkg::ST_EXTRAP : tpbi_pkg::ST_INTERP;
  endfunction

  // Work out the result of one accepted request and queue it.
  function automatic void predict_pose(pose_req_t q);
    pose_res_t r;
    if (q.cmd == CMD_UNUSED) return;
    r = '{st: tpbi_pkg::ST_EMPTY, t: q.t, x: 0, y: 0, z: 0, hd: 0, pt: 0, rl: 0};
    if (q.cmd == tpbi_pkg::CMD_PUSH) begin
      r.st = push_pose(q);
    end else if (q.cmd == tpbi_pkg::CMD_QUERY) begin
      r.st = query_pose(q.t, r);
    end else if (buf_n == 0) begin
      r.t = '0;
    end else begin
      load_entry(buf_n - 1, r);
      r.st = tpbi_pkg::ST_LATEST;
      r.t = buf_t[buf_n - 1];
    end
    expected_poses.push_back(r);
  endfunction

  // Request driver with random idle bursts between requests.
  int src_gap = 0;
  always @(posedge clk) begin
    logic busy;
    busy = s_tvalid;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_pose(pending.pop_front());
        n_req++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 11) == 0) begin
          src_gap = $urandom_range(0, 15);
          s_tvalid <= 1'b0;
        end else if (pending.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tuser <= pending[0].cmd;
          s_tdata <= {pending[0].rl, pending[0].pt, pending[0].hd, pending[0].z,
                      pending[0].y, pending[0].x, pending[0].t};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result sink with random stalls.
  int snk_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (snk_gap > 0) begin
        snk_gap--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        snk_gap = $urandom_range(0, 15);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Result monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    pose_res_t e;
    if (!rst && m_tvalid && m_tready) begin
      n_res++;
      if (expected_poses.size() == 0) begin
        $display("%0t unexpected result: status %0d time %0d", $time, m_tuser, m_tdata[47:0]);
        errors++;
      end else begin
        e = expected_poses.pop_front();
        check_field("status", e.st, m_tuser);
        check_field("time", e.t, m_tdata[47:0]);
        check_field("x", e.x, $signed(m_tdata[79:48]));
        check_field("y", e.y, $signed(m_tdata[111:80]));
        check_field("z", e.z, $signed(m_tdata[143:112]));
        check_field("heading", $signed(e.hd), $signed(m_tdata[161:144]));
        check_field("pitch", e.pt, $signed(m_tdata[177:162]));
        check_field("roll", e.rl, $signed(m_tdata[193:178]));
        check_field("fill", 0, m_tdata[199:194]);
      end
    end
  end

  // Watchdog on cycles without any handshake.
  int quiet = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else if (quiet >= WATCH_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet);
      $display("CHECK FAILED");
      $finish;
    end else
      quiet <= quiet + 1;
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == tpbi_pkg::CFG_DEPTH) depth_reg = val[4:0];
    else if (idx == tpbi_pkg::CFG_EXT_EN) extrap_en = val[0];
    else extrap_lim = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_all();
    while (pending.size() > 0 || s_tvalid || expected_poses.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic setup(logic [4:0] dep, logic en, logic [31:0] lim);
    drain_all();
    write_reg(tpbi_pkg::CFG_DEPTH, {27'd0, dep});
    write_reg(tpbi_pkg::CFG_EXT_EN, {31'd0, en});
    write_reg(tpbi_pkg::CFG_EXT_LIM, lim);
  endtask

  function automatic pose_req_t mk(logic [1:0] c, logic [47:0] t, logic [31:0] x,
                                   logic [31:0] y, logic [31:0] z, logic [15:0] h,
                                   logic [15:0] p, logic [15:0] r);
    return '{cmd: c, t: t, x: x, y: y, z: z, hd: h, pt: p, rl: r};
  endfunction

  function automatic pose_req_t rand_push(logic [47:0] t);
    pose_req_t q;
    int sel;
    sel = $urandom_range(0, 9);
    q = mk(tpbi_pkg::CMD_PUSH, t, $urandom, $urandom, $urandom, 16'($urandom),
           16'($urandom), 16'($urandom));
    if (sel < 6) begin
      // Mostly moderate values, with headings often near north.
      q.x = $signed($urandom_range(0, 2000000)) - 1000000;
      q.y = $signed($urandom_range(0, 2000000)) - 1000000;
      q.z = $signed($urandom_range(0, 20000)) - 10000;
      q.hd = 16'($urandom_range(0, 1) ? $urandom_range(0, 35999)
                                      : ($urandom_range(0, 1) ? $urandom_range(30001, 35999)
                                                              : $urandom_range(0, 9999)));
      q.pt = 16'($signed($urandom_range(0, 18000)) - 9000);
      q.rl = 16'($signed($urandom_range(0, 18000)) - 9000);
    end else if (sel == 6) begin
      q.x = 32'h7FFF_FFFF; q.y = 32'h8000_0000; q.pt = 16'h7FFF; q.rl = 16'h8000;
    end else if (sel == 7) begin
      q.x = 32'h8000_0000; q.y = 32'h7FFF_FFFF; q.pt = 16'h8000; q.rl = 16'h7FFF;
    end
    return q;
  endfunction

  // One phase of random requests around a moving time base.
  task automatic random_phase(int count, logic [47:0] base);
    logic [47:0] tb, qt;
    int r;
    tb = base;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        if ($urandom_range(0, 19) == 0) qt = tb - $urandom_range(0, 8000);
        else begin
          tb = tb + $urandom_range(1, 3000);
          qt = tb;
        end
        pending.push_back(rand_push(qt));
      end else if (r < 80) begin
        if ($urandom_range(0, 9) == 0) qt = tb + 48'({$urandom_range(0, 3), $urandom});
        else if ($urandom_range(0, 9) == 0) qt = tb - $urandom_range(0, 300000);
        else qt = tb + $urandom_range(0, 12000) - 40000;
        pending.push_back(mk(tpbi_pkg::CMD_QUERY, qt, $urandom, $urandom, $urandom,
                             16'($urandom), 16'($urandom), 16'($urandom)));
      end else if (r < 95) begin
        pending.push_back(mk(tpbi_pkg::CMD_LATEST, 48'({$urandom, $urandom}), $urandom,
                             $urandom, $urandom, 16'($urandom), 16'($urandom),
                             16'($urandom)));
      end else begin
        pending.push_back(mk(CMD_UNUSED, 48'({$urandom, $urandom}), $urandom, $urandom,
                             $urandom, 16'($urandom), 16'($urandom), 16'($urandom)));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty store, extreme times and values, single entry, duplicates,
    // exact match at the oldest, interpolation and the azimuth wrap.
    pending.push_back(mk(tpbi_pkg::CMD_LATEST, 48'd5, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(tpbi_pkg::CMD_QUERY, 48'd77, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(tpbi_pkg::CMD_PUSH, 48'd0, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'hFFFF_FFFF, 16'd35999, 16'h7FFF, 16'h8000));
    pending.push_back(mk(tpbi_pkg::CMD_QUERY, 48'd999, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(tpbi_pkg::CMD_PUSH, T_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0,
                         16'd0, 16'h8000, 16'h7FFF));
    pending.push_back(mk(tpbi_pkg::CMD_QUERY, 48'h8000_0000_0000, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(tpbi_pkg::CMD_PUSH, T_MAX, 1, 2, 3, 4, 5, 6));
    pending.push_back(mk(CMD_UNUSED, 48'd123, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(tpbi_pkg::CMD_LATEST, 48'd0, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(tpbi_pkg::CMD_QUERY, 48'd0, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(tpbi_pkg::CMD_PUSH, 48'd1000, 32'h0001_0000, 32'hFFFF_0000, 32'd7,
                         16'd35000, 16'd100, -16'sd100));
    pending.push_back(mk(tpbi_pkg::CMD_PUSH, 48'd2000, 32'h0003_0000, 32'hFFFD_0000, 32'd9,
                         16'd500, 16'd300, -16'sd300));
    pending.push_back(mk(tpbi_pkg::CMD_QUERY, 48'd1500, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(tpbi_pkg::CMD_QUERY, 48'd1100, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(tpbi_pkg::CMD_PUSH, 48'd1500, 5, 5, 5, 16'd65535, 0, 0));
    pending.push_back(mk(tpbi_pkg::CMD_QUERY, 48'd1250, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(tpbi_pkg::CMD_LATEST, 48'd0, 0, 0, 0, 0, 0, 0));

    // Extrapolation on, both inside and beyond the limit.
    setup(5'd3, 1'b1, 32'd100000);
    pending.push_back(mk(tpbi_pkg::CMD_PUSH, 48'd10000, 32'h7FFF_0000, 0, 0, 16'd34000,
                         16'd32000, 0));
    pending.push_back(mk(tpbi_pkg::CMD_PUSH, 48'd20000, 32'h7FFF_FFFF, 0, 0, 16'd35900,
                         16'd32767, 0));
    pending.push_back(mk(tpbi_pkg::CMD_QUERY, 48'd90000, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(tpbi_pkg::CMD_QUERY, 48'd500000, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(tpbi_pkg::CMD_QUERY, 48'd5000, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(tpbi_pkg::CMD_PUSH, 48'd30000, 1, 1, 1, 16'd1, 16'd1, 16'd1));
    pending.push_back(mk(tpbi_pkg::CMD_PUSH, 48'd40000, 2, 2, 2, 16'd2, 16'd2, 16'd2));
    pending.push_back(mk(tpbi_pkg::CMD_LATEST, 48'd0, 0, 0, 0, 0, 0, 0));

    // Random phases across register settings; the drains hold requests back
    // until every result has come.
    random_phase(230, 48'd0);
    setup(5'd0, 1'b1, 32'd0);
    random_phase(150, 48'({$urandom_range(0, 65535), $urandom}));
    setup(5'd31, 1'b1, 32'hFFFF_FFFF);
    random_phase(230, 48'd100);
    setup(5'd16, 1'b0, 32'd5000);
    random_phase(200, 48'({$urandom_range(0, 65535), $urandom}));
    setup(5'd2, 1'b1, 32'd30000);
    random_phase(200, 48'hFFFF_FFF0_0000);
    // Lowering the depth under the stored count evicts only one per push.
    setup(5'd1, 1'b1, $urandom);
    random_phase(80, 48'd5000);
    setup(5'd6, 1'b1, 32'd200000);
    random_phase(200, 48'd0);
    drain_all();
    idle_on = 1'b0;
    random_phase(130, 48'h0000_1234_0000);
    drain_all();

    $display("requests %0d, results %0d, blended results %0d, over eight register settings",
             n_req, n_res, n_blend);
    $display("covered push/evict/duplicate, interpolation, extrapolation and held cases");
    if (errors == 0 && expected_poses.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/tpbi_pkg.sv
design/tpbi_ram.sv
design/tpbi_muldiv.sv
design/timestamped_pose_buffer_interp.sv
design/tpbi_chk.sv
dv/tb_timestamped_pose_buffer_interp.sv
